[design/lmb_pkg.sv]
// Shared constants and types of the local mean binarizer.
package lmb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 15;
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(STORE_ROWS);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int ROW_W  = 16;
  localparam int WID_W  = 11;
  localparam int RAD_W  = 4;
  localparam int PIX_W  = 10;
  localparam int CSUM_W = 15;
  localparam int WSUM_W = 20;
  localparam int CNT_W  = 10;
  localparam int PEND_W = 15;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_COL,
    ST_CWAIT,
    ST_SUB,
    ST_SUBW,
    ST_CMP,
    ST_OUT
  } lmb_state_e;

endpackage

[design/local_mean_binarizer.sv]
// Local mean binarizer: adaptive threshold over a clipped square window.
//
// Pixels enter on the slave stream in raster order, tdata = {blue, green, red}
// and tuser = flush. Each pixel's brightness (r+g+b) goes into a line store
// holding the last 32 rows. A binarized pixel leaves on the master stream once
// radius rows and radius pixels more have arrived; tdata bit 0 is white and
// tlast marks the last pixel of the frame. After the last input pixel, flush
// items (or further pixels) drain the pending outputs, one per item.
// The window sum is kept incrementally: per output pixel one new column sum
// is built by reading the line store once per window row, none once the
// window touches the right edge, and the column sum that leaves the window is
// read back from the column sum memory. The first pixel of a row builds all
// starting columns. The line store read port gives one row per cycle. An item
// that causes no result leaves the input ready for the next item; an item
// with a result holds the input until its result enters the output register.
// Reset sets width 1024, height 1, radius 1 and clears all counters; the
// memories need no clearing, since every entry read was written in the
// current frame. A configuration write restarts the frame.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and worked on, and its result waits for the register.
module local_mean_binarizer
  import lmb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic               s_axis_tuser,   // flush
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // white[0], zero padding above
  output logic               m_axis_tlast,   // frame_end
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers, raw as written.
  logic [WID_W-1:0] width_q;
  logic [ROW_W-1:0] height_q;
  logic [RAD_W-1:0] radius_q;
  logic             cfg_we;
  logic             cfg_restart;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  // A write to an unused index leaves the current frame running.
  assign cfg_restart = cfg_we && (paddr[3:2] <= REG_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(MAX_WIDTH);
      height_q <= ROW_W'(1);
      radius_q <= RAD_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
        REG_HEIGHT: height_q <= pwdata[ROW_W-1:0];
        REG_RADIUS: radius_q <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_RADIUS: prdata = 32'(radius_q);
      default:    prdata = 32'd0;
    endcase
  end

  // Effective geometry: zero width or height acts as one, width saturates.
  // The 4-bit radius cannot exceed the maximum radius of 15.
  logic [WID_W-1:0]  w_eff;
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_eff;
  logic [ROW_W-1:0]  h_last;
  logic [RAD_W-1:0]  rad;
  logic [PEND_W-1:0] delay;

  always_comb begin
    if (width_q == '0)
      w_eff = WID_W'(1);
    else if (width_q > WID_W'(MAX_WIDTH))
      w_eff = WID_W'(MAX_WIDTH);
    else
      w_eff = width_q;
    h_eff  = (height_q == '0) ? ROW_W'(1) : height_q;
    w_last = COL_W'(w_eff - WID_W'(1));
    h_last = h_eff - ROW_W'(1);
    rad    = radius_q;
    delay  = PEND_W'(rad) * PEND_W'(w_eff) + PEND_W'(rad);
  end

  // Memories: brightness line store and per-column window sums.
  logic [PIX_W-1:0]  line_mem [2**ADDR_W];
  logic [CSUM_W-1:0] csum_mem [MAX_WIDTH];

  logic              ls_we;
  logic [ADDR_W-1:0] ls_waddr;
  logic [PIX_W-1:0]  ls_wdata;
  logic [ADDR_W-1:0] ls_raddr;
  logic [PIX_W-1:0]  ls_rdata;
  logic              cs_we;
  logic [COL_W-1:0]  cs_waddr;
  logic [CSUM_W-1:0] cs_wdata;
  logic [COL_W-1:0]  cs_raddr;
  logic [CSUM_W-1:0] cs_rdata;

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      line_mem[ls_waddr] <= ls_wdata;
    end
    ls_rdata <= line_mem[ls_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      csum_mem[cs_waddr] <= cs_wdata;
    end
    cs_rdata <= csum_mem[cs_raddr];
  end

  // Sequencer and datapath state.
  lmb_state_e        state_q, state_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic              rd_vld_q, rd_vld_d;
  logic              m_valid_q, m_valid_d;

  logic [ROW_W-1:0]  r0_q, r0_d, r1_q, r1_d, y_q, y_d;
  logic [COL_W-1:0]  c0_q, c0_d, c1_q, c1_d, x_q, x_d;
  logic [CSUM_W-1:0] s_q, s_d;
  logic [WSUM_W-1:0] ws_q, ws_d;
  logic              sub_q, sub_d;
  logic [PIX_W-1:0]  centre_q, centre_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              white_q, white_d;
  logic              m_white_q, m_white_d, m_last_q, m_last_d;

  logic              accept;
  logic              in_done, is_pix, emit;
  logic [ROW_W:0]    r_hi;
  logic [COL_W:0]    c_hi;
  logic [CSUM_W-1:0] s_fin;
  logic [SLOT_W-1:0] n_rows;
  logic [SLOT_W-1:0] n_cols;
  logic [WSUM_W-1:0] prod;
  logic              out_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_done       = (in_row_q == h_eff);
  assign is_pix        = !s_axis_tuser && !in_done;
  assign out_last      = (out_row_q == h_last) && (out_col_q == w_last);

  always_comb begin
    state_d   = state_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    pend_d    = pend_q;
    rd_vld_d  = 1'b0;
    m_valid_d = m_valid_q;
    r0_d      = r0_q;
    r1_d      = r1_q;
    c0_d      = c0_q;
    c1_d      = c1_q;
    x_d       = x_q;
    y_d       = y_q;
    s_d       = s_q;
    ws_d      = ws_q;
    sub_d     = sub_q;
    centre_d  = centre_q;
    count_d   = count_q;
    white_d   = white_q;
    m_white_d = m_white_q;
    m_last_d  = m_last_q;

    ls_we    = 1'b0;
    ls_waddr = {in_row_q[SLOT_W-1:0], in_col_q};
    ls_wdata = PIX_W'(s_axis_tdata[7:0]) + PIX_W'(s_axis_tdata[15:8])
             + PIX_W'(s_axis_tdata[23:16]);
    ls_raddr = {y_q[SLOT_W-1:0], x_q};
    cs_we    = 1'b0;
    cs_waddr = x_q;
    s_fin    = s_q + CSUM_W'(ls_rdata);
    cs_wdata = s_fin;
    cs_raddr = COL_W'(out_col_q - COL_W'(rad) - COL_W'(1));
    emit     = 1'b0;

    r_hi   = {1'b0, out_row_q} + (ROW_W+1)'(rad);
    c_hi   = {1'b0, out_col_q} + (COL_W+1)'(rad);
    n_rows = SLOT_W'(r1_q - r0_q) + SLOT_W'(1);
    n_cols = SLOT_W'(c1_q - c0_q) + SLOT_W'(1);
    prod   = WSUM_W'(centre_q) * WSUM_W'(count_q);

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_pix) begin
            ls_we  = 1'b1;
            pend_d = pend_q + PEND_W'(1);
            if (in_col_q == w_last) begin
              in_col_d = '0;
              in_row_d = in_row_q + ROW_W'(1);
            end else begin
              in_col_d = in_col_q + COL_W'(1);
            end
            emit = (pend_d > delay) || ((in_col_q == w_last) && (in_row_q == h_last));
          end else begin
            emit = in_done;
          end
          if (emit) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        r1_d = (r_hi > {1'b0, h_last}) ? h_last : r_hi[ROW_W-1:0];
        r0_d = (out_row_q > ROW_W'(rad)) ? out_row_q - ROW_W'(rad) : '0;
        c1_d = (c_hi > {1'b0, w_last}) ? w_last : c_hi[COL_W-1:0];
        c0_d = (out_col_q > COL_W'(rad)) ? out_col_q - COL_W'(rad) : '0;
        y_d  = r0_d;
        s_d  = '0;
        x_d  = (out_col_q == '0) ? '0 : c1_d;
        if (out_col_q == '0) begin
          ws_d = '0;
        end
        // A new column enters on the first pixel of a row, or when the
        // right edge of the window is still inside the image.
        if ((out_col_q == '0) || (c_hi <= {1'b0, w_last})) begin
          state_d = ST_COL;
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_COL: begin
        // One line store read per window row; the registered data follows in the next cycle.
        rd_vld_d = 1'b1;
        if (rd_vld_q) begin
          s_d = s_fin;
        end
        if (y_q == r1_q) begin
          state_d = ST_CWAIT;
        end else begin
          y_d = y_q + ROW_W'(1);
        end
      end
      ST_CWAIT: begin
        cs_we = 1'b1;
        ws_d  = ws_q + WSUM_W'(s_fin);
        if (x_q == c1_q) begin
          state_d = ST_SUB;
        end else begin
          x_d     = x_q + COL_W'(1);
          y_d     = r0_q;
          s_d     = '0;
          state_d = ST_COL;
        end
      end
      ST_SUB: begin
        // The leaving column was written earlier in this row, never in this
        // emit, so the read cannot meet a pending write.
        ls_raddr = {out_row_q[SLOT_W-1:0], out_col_q};
        sub_d    = out_col_q > COL_W'(rad);
        state_d  = ST_SUBW;
      end
      ST_SUBW: begin
        centre_d = ls_rdata;
        if (sub_q) begin
          ws_d = ws_q - WSUM_W'(cs_rdata);
        end
        count_d = CNT_W'(n_rows) * CNT_W'(n_cols);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        white_d = prod > ws_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_white_d = white_q;
          m_last_d  = out_last;
          state_d   = ST_IDLE;
          if (out_last) begin
            in_row_d  = '0;
            in_col_d  = '0;
            out_row_d = '0;
            out_col_d = '0;
            pend_d    = '0;
          end else begin
            pend_d = pend_q - PEND_W'(1);
            if (out_col_q == w_last) begin
              out_col_d = '0;
              out_row_d = out_row_q + ROW_W'(1);
            end else begin
              out_col_d = out_col_q + COL_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      pend_q    <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
      if (cfg_restart) begin
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        pend_q    <= '0;
      end else begin
        in_row_q  <= in_row_d;
        in_col_q  <= in_col_d;
        out_row_q <= out_row_d;
        out_col_q <= out_col_d;
        pend_q    <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q      <= r0_d;
    r1_q      <= r1_d;
    c0_q      <= c0_d;
    c1_q      <= c1_d;
    x_q       <= x_d;
    y_q       <= y_d;
    s_q       <= s_d;
    ws_q      <= ws_d;
    sub_q     <= sub_d;
    centre_q  <= centre_d;
    count_q   <= count_d;
    white_q   <= white_d;
    m_white_q <= m_white_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_white_q};
  assign m_axis_tlast  = m_last_q;

endmodule

[design/lmb_checker.sv]
// Port-level checks for the local mean binarizer, bound to the top level.
module lmb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A new result is loaded only from a busy cycle of the sequencer.
  a_load_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work in progress");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_padding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("padding bits of result not zero");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid && s_axis_tready)
    else $error("outputs not idle in reset");

endmodule

bind local_mean_binarizer lmb_checker u_lmb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
